FILE: hdl/uwrap_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwrap_pkg
// Shared types, codes and helper functions of the UTF-8 line wrapper.
// ----------------------------------------------------------------------------
package uwrap_pkg;

  // configuration register indexes
  localparam logic REG_MAX_WIDTH = 1'b0;
  localparam logic REG_FONT_SIZE = 1'b1;

  localparam int CFG_W        = 16;
  localparam int MAX_WIDTH_W  = 16;
  localparam int FONT_SIZE_W  = 10;
  localparam logic [FONT_SIZE_W-1:0] FONT_SIZE_RESET = 10'd12;

  localparam int JOB_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  localparam int CP_W  = 21;
  localparam int LW_W  = 17;
  localparam int X_W   = 18;
  localparam int ADV_W = 12;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 25;
  localparam logic [RECIP_W-1:0] RECIP_100 = 19'd335545;
  localparam logic [X_W-1:0] ROUND_HALF = 18'd50;

  // job kinds between the decoder and the layout stage
  localparam logic [1:0] KIND_GLYPH = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [CP_W-1:0] CP_NUL    = 21'h00000;
  localparam logic [CP_W-1:0] CP_TAB    = 21'h00009;
  localparam logic [CP_W-1:0] CP_LF     = 21'h0000A;
  localparam logic [CP_W-1:0] CP_CR     = 21'h0000D;
  localparam logic [CP_W-1:0] CP_SPACE  = 21'h00020;
  localparam logic [CP_W-1:0] CP_ASCII  = 21'h00080;
  localparam logic [CP_W-1:0] CP_CJK_LO = 21'h02E80;
  localparam logic [CP_W-1:0] CP_CJK_HI = 21'h09FFF;
  localparam logic [CP_W-1:0] CP_CMP_LO = 21'h0F900;
  localparam logic [CP_W-1:0] CP_CMP_HI = 21'h0FAFF;
  localparam logic [CP_W-1:0] CP_EMOJI  = 21'h1F000;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic [7:0] PCT_TAB   = 8'd220;
  localparam logic [7:0] PCT_SPACE = 8'd35;
  localparam logic [7:0] PCT_DIGIT = 8'd56;
  localparam logic [7:0] PCT_PUNCT = 8'd45;
  localparam logic [7:0] PCT_UPPER = 8'd62;
  localparam logic [7:0] PCT_OTHER = 8'd56;
  localparam logic [7:0] PCT_WIDE  = 8'd100;
  localparam logic [7:0] PCT_EMOJI = 8'd110;
  localparam logic [7:0] PCT_REST  = 8'd75;

  typedef struct packed {
    logic [1:0]      kind;
    logic            end_step;
    logic [2:0]      len;
    logic [CP_W-1:0] cp;
    logic [3:0][7:0] bytes;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       brk;
    logic       done;
  } out_beat_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (b[7:5] == 3'b110) n = 3'd2;
    else if (b[7:4] == 4'b1110) n = 3'd3;
    else if (b[7:3] == 5'b11110) n = 3'd4;
    else n = 3'd1;
    return n;
  endfunction

  function automatic logic [7:0] adv_pct(input logic [CP_W-1:0] cp);
    logic [7:0] p;
    if (cp == CP_TAB) p = PCT_TAB;
    else if (cp == CP_SPACE) p = PCT_SPACE;
    else if (cp < CP_ASCII) begin
      if (cp >= 21'h30 && cp <= 21'h39) p = PCT_DIGIT;
      else if ((cp >= 21'h21 && cp <= 21'h2F) || (cp >= 21'h3A && cp <= 21'h40) ||
               (cp >= 21'h5B && cp <= 21'h60) || (cp >= 21'h7B && cp <= 21'h7E))
        p = PCT_PUNCT;
      else if (cp >= 21'h41 && cp <= 21'h5A) p = PCT_UPPER;
      else p = PCT_OTHER;
    end else if ((cp >= CP_CJK_LO && cp <= CP_CJK_HI) ||
                 (cp >= CP_CMP_LO && cp <= CP_CMP_HI))
      p = PCT_WIDE;
    else if (cp >= CP_EMOJI) p = PCT_EMOJI;
    else p = PCT_REST;
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/uwrap_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwrap_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module uwrap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty,
  output logic                  full
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/uwrap_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwrap_front
// Accepts text bytes, assembles UTF-8 sequences and issues glyph, raw and end jobs.
// ----------------------------------------------------------------------------
module uwrap_front
  import uwrap_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_push,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end,
  output logic            in_ready,
  input  wire logic       pass_thru,
  input  wire logic       job_full,
  output logic            job_push,
  output job_t            job
);
  logic            cur_valid;
  logic [7:0]      cur_byte;
  logic            cur_end;
  logic            tail;
  logic [2:0][7:0] pend;
  logic [1:0]      pcnt;
  logic            flushing;

  logic [2:0][7:0] pend_next;
  logic [1:0]      pcnt_next;
  logic            flushing_next;
  logic            job_req;
  logic            consumed;
  logic            finish;
  logic            go;
  logic            step_done;
  logic            cont;
  logic [2:0]      need;

  assign cont = (cur_byte[7:6] == 2'b10);
  assign need = seq_len(pend[0]);

  always_comb begin
    job_req       = 1'b0;
    job           = '0;
    job.kind      = KIND_GLYPH;
    job.len       = 3'd1;
    job.end_step  = cur_end;
    pend_next     = pend;
    pcnt_next     = pcnt;
    flushing_next = flushing;
    consumed      = 1'b0;
    finish        = 1'b0;
    if (tail) begin
      job_req = 1'b1;
      if (pcnt != 2'd0) begin
        job.cp       = {13'b0, pend[0]};
        job.bytes[0] = pend[0];
        pend_next[0] = pend[1];
        pend_next[1] = pend[2];
        pcnt_next    = pcnt - 2'd1;
      end else begin
        job.kind      = KIND_END;
        finish        = 1'b1;
        flushing_next = 1'b0;
      end
    end else if (pass_thru) begin
      job_req  = 1'b1;
      job.kind = KIND_RAW;
      if (pcnt != 2'd0) begin
        job.bytes[0] = pend[0];
        pend_next[0] = pend[1];
        pend_next[1] = pend[2];
        pcnt_next    = pcnt - 2'd1;
      end else begin
        job.bytes[0] = cur_byte;
        consumed     = 1'b1;
      end
    end else if (flushing || (pcnt != 2'd0 && !(cont && {1'b0, pcnt} < need))) begin
      // malformed sequence: held bytes leave one by one
      job_req       = 1'b1;
      job.cp        = {13'b0, pend[0]};
      job.bytes[0]  = pend[0];
      pend_next[0]  = pend[1];
      pend_next[1]  = pend[2];
      pcnt_next     = pcnt - 2'd1;
      flushing_next = (pcnt > 2'd1);
    end else if (pcnt != 2'd0) begin
      consumed = 1'b1;
      if ({1'b0, pcnt} + 3'd1 == need) begin
        job_req      = 1'b1;
        job.len      = need;
        job.bytes[0] = pend[0];
        pcnt_next    = 2'd0;
        case (need)
          3'd2: begin
            job.cp       = {10'b0, pend[0][4:0], cur_byte[5:0]};
            job.bytes[1] = cur_byte;
          end
          3'd3: begin
            job.cp       = {5'b0, pend[0][3:0], pend[1][5:0], cur_byte[5:0]};
            job.bytes[1] = pend[1];
            job.bytes[2] = cur_byte;
          end
          default: begin
            job.cp       = {pend[0][2:0], pend[1][5:0], pend[2][5:0], cur_byte[5:0]};
            job.bytes[1] = pend[1];
            job.bytes[2] = pend[2];
            job.bytes[3] = cur_byte;
          end
        endcase
      end else begin
        pend_next[pcnt] = cur_byte;
        pcnt_next       = pcnt + 2'd1;
      end
    end else begin
      consumed = 1'b1;
      if (seq_len(cur_byte) == 3'd1) begin
        job_req      = 1'b1;
        job.cp       = {13'b0, cur_byte};
        job.bytes[0] = cur_byte;
      end else begin
        pend_next[0] = cur_byte;
        pcnt_next    = 2'd1;
      end
    end
  end

  assign go        = cur_valid && (!job_req || !job_full);
  assign step_done = finish || (consumed && !cur_end);
  assign in_ready  = !cur_valid || (go && step_done);
  assign job_push  = go && job_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      tail      <= 1'b0;
      pcnt      <= 2'd0;
      flushing  <= 1'b0;
    end else begin
      if (go) begin
        pend     <= pend_next;
        pcnt     <= pcnt_next;
        flushing <= flushing_next;
        if (consumed && cur_end) begin
          tail <= 1'b1;
        end
        if (step_done) begin
          cur_valid <= 1'b0;
          tail      <= 1'b0;
        end
      end
      if (in_push && in_ready) begin
        cur_valid <= 1'b1;
        cur_byte  <= in_byte;
        cur_end   <= in_end;
        tail      <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/uwrap_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwrap_back
// Computes glyph advances, tracks the line width and emits output beats.
// ----------------------------------------------------------------------------
module uwrap_back
  import uwrap_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   job_empty,
  input  wire job_t                   job,
  output logic                        job_pop,
  input  wire logic [MAX_WIDTH_W-1:0] max_width,
  input  wire logic [FONT_SIZE_W-1:0] font_size,
  input  wire logic                   out_full,
  output logic                        out_push,
  output out_beat_t                   out_beat
);
  localparam int QP_W = X_W + RECIP_W;

  // advance: scale stage
  logic [FONT_SIZE_W-1:0] scale;
  logic [X_W-1:0]         prod;
  logic [X_W-1:0]         x_d;
  logic                   b_valid;
  job_t                   b_job;
  logic [X_W-1:0]         b_x;
  logic [QP_W-1:0]        qprod;
  logic [ADV_W-1:0]       adv_d;
  logic                   b_move;

  // layout stage
  logic             c_valid;
  job_t             c_job;
  logic [ADV_W-1:0] c_adv;
  logic [2:0]       c_idx;
  logic [2:0]       c_nb;
  logic             c_brk;
  logic             c_lf;
  logic [LW_W-1:0]  line_width;
  logic             stopped;
  logic             hold_valid;
  out_beat_t        hold;

  logic             first;
  logic [LW_W:0]    sum;
  logic             f_skip;
  logic             f_lf;
  logic             f_brk;
  logic [2:0]       f_nb;
  logic [2:0]       d_nb;
  logic             d_brk;
  logic             d_lf;
  logic [2:0]       sel;
  out_beat_t        beat;
  logic             is_end;
  logic             is_raw;
  logic             need_out;
  logic             stall;
  logic             last;
  logic             c_go;
  logic             c_done;

  assign scale = (font_size == '0) ? FONT_SIZE_W'(1) : font_size;
  assign prod  = {{(X_W-FONT_SIZE_W){1'b0}}, scale} * {{(X_W-8){1'b0}}, adv_pct(job.cp)};
  assign x_d   = prod + ROUND_HALF;

  // divide by 100 through the reciprocal
  assign qprod = {{RECIP_W{1'b0}}, b_x} * {{X_W{1'b0}}, RECIP_100};
  assign adv_d = qprod[RECIP_SHIFT +: ADV_W];

  assign is_end = (c_job.kind == KIND_END);
  assign is_raw = (c_job.kind == KIND_RAW);
  assign first  = (c_idx == 3'd0);
  assign sum    = {1'b0, line_width} + {{(LW_W+1-ADV_W){1'b0}}, c_adv};
  assign f_skip = stopped || (c_job.cp == CP_NUL) || (c_job.cp == CP_CR);
  assign f_lf   = (c_job.cp == CP_LF);
  assign f_brk  = (line_width != '0) &&
                  (sum > {{(LW_W+1-MAX_WIDTH_W){1'b0}}, max_width});
  assign f_nb   = f_skip ? 3'd0 : (f_lf ? 3'd1 : c_job.len + {2'b0, f_brk});
  assign d_nb   = first ? f_nb : c_nb;
  assign d_brk  = first ? f_brk : c_brk;
  assign d_lf   = first ? f_lf : c_lf;
  assign sel    = c_idx - {2'b0, d_brk};

  always_comb begin
    beat      = '0;
    beat.has  = 1'b1;
    if (is_raw) begin
      beat.data = c_job.bytes[0];
    end else if (d_lf) begin
      beat.data = BYTE_LF;
    end else if (d_brk && first) begin
      beat.data = BYTE_LF;
      beat.brk  = 1'b1;
    end else begin
      beat.data = c_job.bytes[sel[1:0]];
    end
  end

  assign need_out = is_end || is_raw || (d_nb != 3'd0);
  assign stall    = need_out && out_full;
  assign last     = is_end || is_raw || (d_nb == 3'd0) || (c_idx == d_nb - 3'd1);
  assign c_go     = c_valid && !stall;
  assign c_done   = c_go && last;
  assign b_move   = b_valid && (!c_valid || c_done);
  assign job_pop  = !job_empty && (!b_valid || b_move);

  // beats of a final step pass through the hold register so the last one can be marked
  always_comb begin
    out_push = 1'b0;
    out_beat = beat;
    if (c_go) begin
      if (is_end) begin
        out_push = 1'b1;
        if (hold_valid) begin
          out_beat = hold;
        end else begin
          out_beat = '0;
        end
        out_beat.done = 1'b1;
      end else if (need_out) begin
        if (c_job.end_step) begin
          out_push = hold_valid;
          out_beat = hold;
        end else begin
          out_push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      line_width <= '0;
      stopped    <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (c_go) begin
        if (is_end) begin
          line_width <= '0;
          stopped    <= 1'b0;
          hold_valid <= 1'b0;
        end else begin
          if (first && c_job.kind == KIND_GLYPH) begin
            c_nb  <= f_nb;
            c_brk <= f_brk;
            c_lf  <= f_lf;
            if (!stopped && c_job.cp == CP_NUL) begin
              stopped <= 1'b1;
            end
            if (!f_skip) begin
              if (f_lf) begin
                line_width <= '0;
              end else if (f_brk) begin
                line_width <= {{(LW_W-ADV_W){1'b0}}, c_adv};
              end else begin
                line_width <= sum[LW_W-1:0];
              end
            end
          end
          if (need_out && c_job.end_step) begin
            hold       <= beat;
            hold_valid <= 1'b1;
          end
          if (!last) begin
            c_idx <= c_idx + 3'd1;
          end
        end
      end
      if (b_move) begin
        c_valid <= 1'b1;
        c_job   <= b_job;
        c_adv   <= adv_d;
        c_idx   <= 3'd0;
      end else if (c_done) begin
        c_valid <= 1'b0;
      end
      if (job_pop) begin
        b_valid <= 1'b1;
        b_job   <= job;
        b_x     <= x_d;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/utf8_text_line_wrapper.sv
`default_nettype none
// Path: a byte that yields one beat passes the input register, job queue, advance
// stage, layout stage and result queue on its way to the result side.
// Throughput: one byte per cycle while each byte yields at most one beat and the
// result queue has room; every further beat, held byte of a broken sequence and end
// of text holds the input back in the decoder or the layout stage.
// Reset: synchronous, clears queues and text state; max_width 0, font_size 12.
// ----------------------------------------------------------------------------
// utf8_text_line_wrapper
// Greedy line wrapper for a UTF-8 byte stream with queue-style ports.
// ----------------------------------------------------------------------------
module utf8_text_line_wrapper
  import uwrap_pkg::*;
#(
  parameter int JOB_DEPTH = JOB_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       text_byte,
  input  wire logic             end_of_text,
  output logic                  empty,
  input  wire logic             pop,
  output logic      [7:0]       out_byte,
  output logic                  has_byte,
  output logic                  inserted_break,
  output logic                  text_done,
  input  wire logic             cfg_write,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);
  logic [MAX_WIDTH_W-1:0] max_width;
  logic [FONT_SIZE_W-1:0] font_size;

  logic      in_ready;
  logic      job_push;
  job_t      job_in;
  job_t      job_head;
  logic      job_pop;
  logic      job_empty;
  logic      job_full;
  logic      out_push;
  out_beat_t out_beat;
  logic      out_full;
  out_beat_t out_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width <= '0;
      font_size <= FONT_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_WIDTH: max_width <= cfg_data[MAX_WIDTH_W-1:0];
        REG_FONT_SIZE: font_size <= cfg_data[FONT_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign full = !in_ready;

  uwrap_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_push   (push),
    .in_byte   (text_byte),
    .in_end    (end_of_text),
    .in_ready  (in_ready),
    .pass_thru (max_width == '0),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  uwrap_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .pop   (job_pop),
    .rdata (job_head),
    .empty (job_empty),
    .full  (job_full)
  );

  uwrap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .max_width (max_width),
    .font_size (font_size),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_beat  (out_beat)
  );

  uwrap_fifo #(
    .WIDTH ($bits(out_beat_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_beat),
    .pop   (pop),
    .rdata (out_head),
    .empty (empty),
    .full  (out_full)
  );

  assign out_byte       = out_head.data;
  assign has_byte       = out_head.has;
  assign inserted_break = out_head.brk;
  assign text_done      = out_head.done;

`ifndef SYNTHESIS
  // a bare end marker only closes a text
  a_marker_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> (text_done && out_byte == 8'h00 && !inserted_break))
    else $error("bare beat without end of text");

  // an inserted break is always a newline byte
  a_break_lf: assert property (@(posedge clk) disable iff (rst)
    (!empty && inserted_break) |-> (has_byte && out_byte == BYTE_LF))
    else $error("inserted break is not a newline");

  // the result queue comes out of reset empty and no job is pushed
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !job_push))
    else $error("result queue not empty after reset");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the UTF-8 line wrapper. A short table of directed bytes runs first,
// then random texts of well-formed, broken and stray sequences under several
// width and font settings. Each result beat is compared field by field against
// a typed row's beat or a line-wrap predictor kept in step with accepted bytes.
// ----------------------------------------------------------------------------
module testbench;
  import uwrap_pkg::*;

  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic        is_cfg;
    logic        idx;
    logic [15:0] val;
    logic [7:0]  text;
    logic        eot;
    logic        typed;
    out_beat_t   want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       text_byte = 8'h00;
  logic             end_of_text = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [7:0]       out_byte;
  logic             has_byte;
  logic             inserted_break;
  logic             text_done;
  logic             cfg_write = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic      row_typed = 1'b0;
  out_beat_t row_beat = '0;
  int        idle_pct = 14;
  int        mismatches = 0;
  int        beats_seen = 0;
  int        stall_cycles = 0;

  // predictor state
  logic [15:0] wrap_limit = 16'd0;
  logic [9:0]  glyph_size = FONT_SIZE_RESET;
  logic [7:0]  held [3];
  int          held_n = 0;
  logic [16:0] line_px = '0;
  logic        halted = 1'b0;

  out_beat_t   step_beats [$];
  out_beat_t   wrapped_beats [$];
  logic [7:0]  glyph_bytes [$];
  stim_row_t   rows [$];

  utf8_text_line_wrapper u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .text_byte      (text_byte),
    .end_of_text    (end_of_text),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .inserted_break (inserted_break),
    .text_done      (text_done),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void put_beat(logic [7:0] d, logic h, logic b);
    out_beat_t bt;
    if (step_beats.size() >= 8) return;
    bt.data = d;
    bt.has  = h;
    bt.brk  = b;
    bt.done = 1'b0;
    step_beats = {step_beats, bt};
  endfunction

  function automatic void add_row(stim_row_t r);
    rows = {rows, r};
  endfunction

  function automatic void add_byte(logic [7:0] b);
    glyph_bytes = {glyph_bytes, b};
  endfunction

  function automatic int unsigned glyph_advance(int unsigned cp);
    int unsigned s;
    int unsigned pct;
    s = (glyph_size == 0) ? 1 : glyph_size;
    if (cp == CP_TAB) pct = PCT_TAB;
    else if (cp == CP_SPACE) pct = PCT_SPACE;
    else if (cp < CP_ASCII) begin
      if (cp >= 'h30 && cp <= 'h39) pct = PCT_DIGIT;
      else if ((cp >= 'h21 && cp <= 'h2F) || (cp >= 'h3A && cp <= 'h40) ||
               (cp >= 'h5B && cp <= 'h60) || (cp >= 'h7B && cp <= 'h7E)) pct = PCT_PUNCT;
      else if (cp >= 'h41 && cp <= 'h5A) pct = PCT_UPPER;
      else pct = PCT_OTHER;
    end else if ((cp >= CP_CJK_LO && cp <= CP_CJK_HI) || (cp >= CP_CMP_LO && cp <= CP_CMP_HI))
      pct = PCT_WIDE;
    else if (cp >= CP_EMOJI) pct = PCT_EMOJI;
    else pct = PCT_REST;
    return (s * pct + 50) / 100;
  endfunction

  function automatic void lay_glyph(int unsigned cp, logic [3:0][7:0] seq, int len);
    int unsigned adv;
    if (halted) return;
    if (cp == CP_NUL) begin
      halted = 1'b1;
      return;
    end
    if (cp == CP_CR) return;
    if (cp == CP_LF) begin
      put_beat(BYTE_LF, 1'b1, 1'b0);
      line_px = '0;
      return;
    end
    adv = glyph_advance(cp);
    if (line_px > 0 && line_px + adv > wrap_limit) begin
      put_beat(BYTE_LF, 1'b1, 1'b1);
      line_px = '0;
    end
    for (int i = 0; i < len; i++) put_beat(seq[i], 1'b1, 1'b0);
    line_px = line_px + adv;
  endfunction

  function automatic int utf8_len(logic [7:0] b);
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 1;
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) lay_glyph(held[i], {24'h0, held[i]}, 1);
    held_n = 0;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int need;
    int unsigned cp;
    logic [3:0][7:0] seq;
    if (held_n > 0) begin
      need = utf8_len(held[0]);
      if (b[7:6] == 2'b10 && held_n < need) begin
        if (held_n + 1 == need) begin
          seq = '0;
          for (int i = 0; i < held_n; i++) seq[i] = held[i];
          seq[held_n] = b;
          if (need == 2) cp = {seq[0][4:0], seq[1][5:0]};
          else if (need == 3) cp = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
          else cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
          held_n = 0;
          lay_glyph(cp, seq, need);
        end else begin
          held[held_n] = b;
          held_n++;
        end
        return;
      end
      flush_held();
    end
    if (utf8_len(b) == 1) lay_glyph(b, {24'h0, b}, 1);
    else begin
      held[0] = b;
      held_n = 1;
    end
  endfunction

  function automatic void wrap_step(logic [7:0] b, logic eot);
    step_beats.delete();
    if (wrap_limit == 0) begin
      for (int i = 0; i < held_n; i++) put_beat(held[i], 1'b1, 1'b0);
      held_n = 0;
      put_beat(b, 1'b1, 1'b0);
    end else begin
      decode_byte(b);
      if (eot) flush_held();
    end
    if (eot) begin
      if (step_beats.size() == 0) put_beat(8'h00, 1'b0, 1'b0);
      step_beats[step_beats.size() - 1].done = 1'b1;
      for (int i = 0; i < 3; i++) held[i] = 8'h00;
      held_n = 0;
      line_px = '0;
      halted = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch on %0s at beat %0d: got %0h, expected %0h", what, beats_seen, got, want);
  endtask

  always @(posedge clk) begin : beat_check
    out_beat_t want;
    if (!rst) begin
      if (push && !full) begin
        wrap_step(text_byte, end_of_text);
        if (row_typed) wrapped_beats = {wrapped_beats, row_beat};
        else wrapped_beats = {wrapped_beats, step_beats};
      end
      if (pop && !empty) begin
        beats_seen++;
        if (wrapped_beats.size() == 0) report_mismatch("beat with nothing waiting", out_byte, 0);
        else begin
          want = wrapped_beats.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
          if (has_byte !== want.has) report_mismatch("has_byte", has_byte, want.has);
          if (inserted_break !== want.brk)
            report_mismatch("inserted_break", inserted_break, want.brk);
          if (text_done !== want.done) report_mismatch("text_done", text_done, want.done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                           input out_beat_t want);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    text_byte   <= b;
    end_of_text <= e;
    row_typed   <= typed;
    row_beat    <= want;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (wrapped_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_MAX_WIDTH) wrap_limit = val;
    else glyph_size = val[9:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] mw, input logic [9:0] fs);
    logic [5:0] upper;
    upper = 6'($urandom_range(63));
    settle();
    write_reg(REG_MAX_WIDTH, mw);
    write_reg(REG_FONT_SIZE, {upper, fs});
    cfg_write <= 1'b0;
  endtask

  function automatic stim_row_t byte_row(logic [7:0] b, logic e);
    stim_row_t r;
    r = '0;
    r.text = b;
    r.eot = e;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] b, logic e, logic [7:0] d, logic h);
    stim_row_t r;
    r = byte_row(b, e);
    r.typed = 1'b1;
    r.want.data = d;
    r.want.has = h;
    r.want.brk = 1'b0;
    r.want.done = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic idx, logic [15:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic logic [7:0] ascii_byte();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 8'h00;
    if (r < 6) return 8'h0D;
    if (r < 10) return 8'h0A;
    if (r < 14) return 8'h09;
    if (r < 30) return 8'h20;
    if (r < 34) return 8'($urandom_range(1, 31));
    if (r < 36) return 8'h7F;
    return 8'($urandom_range('h21, 'h7E));
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  task automatic make_char();
    int kind;
    int n;
    glyph_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 40) add_byte(ascii_byte());
    else if (kind < 52) begin
      add_byte(8'hC0 | 8'($urandom_range(31)));
      add_byte(cont_byte());
    end else if (kind < 64) begin
      if (kind < 58) add_byte(8'hE4 + 8'($urandom_range(5)));
      else add_byte(8'hE0 | 8'($urandom_range(15)));
      repeat (2) add_byte(cont_byte());
    end else if (kind < 74) begin
      if (kind < 69) begin
        add_byte(8'hF0);
        add_byte(8'h9F);
        repeat (2) add_byte(cont_byte());
      end else begin
        add_byte(8'hF0 | 8'($urandom_range(7)));
        repeat (3) add_byte(cont_byte());
      end
    end else if (kind < 86) begin
      // lead cut short by a non-continuation byte
      n = $urandom_range(2, 4);
      if (n == 2) add_byte(8'hC0 | 8'($urandom_range(31)));
      else if (n == 3) add_byte(8'hE0 | 8'($urandom_range(15)));
      else add_byte(8'hF0 | 8'($urandom_range(7)));
      repeat ($urandom_range(0, n - 2)) add_byte(cont_byte());
      if ($urandom_range(1)) add_byte(ascii_byte());
      else add_byte(8'hC0 | 8'($urandom_range(63)));
    end else add_byte(8'($urandom_range(255)));
  endtask

  initial begin : main
    int phase;
    int n;
    int sent;
    logic last;
    logic [15:0] mw;
    logic [9:0] fs;
    out_beat_t no_beat;
    no_beat = '0;
    sent = 0;
    phase = 0;

    // pass-through after reset
    add_row(typed_row(8'h41, 1'b1, 8'h41, 1'b1));
    add_row(typed_row(8'hFF, 1'b1, 8'hFF, 1'b1));
    add_row(typed_row(8'h00, 1'b1, 8'h00, 1'b1));
    add_row(cfg_row(REG_MAX_WIDTH, 16'd13));
    add_row(cfg_row(REG_FONT_SIZE, 16'd12));
    // zero stops, carriage return dropped, newline kept
    add_row(typed_row(8'h00, 1'b1, 8'h00, 1'b0));
    add_row(typed_row(8'h0D, 1'b1, 8'h00, 1'b0));
    add_row(typed_row(8'h0A, 1'b1, 8'h0A, 1'b1));
    add_row(byte_row(8'h41, 1'b0));
    add_row(byte_row(8'h41, 1'b0));
    add_row(byte_row(8'hC3, 1'b0));
    add_row(byte_row(8'hA9, 1'b0));
    add_row(byte_row(8'hE4, 1'b0));
    add_row(byte_row(8'hB8, 1'b0));
    add_row(byte_row(8'hAD, 1'b0));
    add_row(byte_row(8'hF0, 1'b0));
    add_row(byte_row(8'h9F, 1'b0));
    add_row(byte_row(8'h98, 1'b0));
    add_row(byte_row(8'h80, 1'b0));
    // broken lead, then truncated at end
    add_row(byte_row(8'hC3, 1'b0));
    add_row(byte_row(8'h41, 1'b0));
    add_row(byte_row(8'hE2, 1'b0));
    add_row(byte_row(8'h82, 1'b1));
    // stray continuation
    add_row(typed_row(8'h80, 1'b1, 8'h80, 1'b1));
    // overlong zero stops the text
    add_row(byte_row(8'h09, 1'b0));
    add_row(byte_row(8'hC0, 1'b0));
    add_row(typed_row(8'h80, 1'b1, 8'h00, 1'b0));
    add_row(cfg_row(REG_MAX_WIDTH, 16'hFFFF));
    add_row(cfg_row(REG_FONT_SIZE, 16'd1023));
    add_row(typed_row(8'h09, 1'b1, 8'h09, 1'b1));
    add_row(cfg_row(REG_FONT_SIZE, 16'd0));
    add_row(cfg_row(REG_MAX_WIDTH, 16'd1));
    add_row(byte_row(8'h41, 1'b0));
    add_row(byte_row(8'h41, 1'b1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        write_reg(rows[i].idx, rows[i].val);
        cfg_write <= 1'b0;
      end else begin
        send_byte(rows[i].text, rows[i].eot, rows[i].typed, rows[i].want);
        sent++;
      end
    end

    while (sent < 230) begin
      if (phase == 0) begin
        mw = 16'hFFFF;
        fs = 10'd1023;
      end else if (phase == 1) begin
        mw = 16'd1;
        fs = 10'd0;
      end else begin
        case ($urandom_range(5))
          0: mw = 16'd0;
          1: mw = 16'($urandom_range(1, 65535));
          default: mw = 16'($urandom_range(8, 200));
        endcase
        case ($urandom_range(4))
          0: fs = 10'($urandom_range(0, 1023));
          1: fs = 10'($urandom_range(0, 1));
          default: fs = 10'($urandom_range(6, 40));
        endcase
      end
      set_config(mw, fs);
      idle_pct <= (phase == 2) ? 0 : 14;
      n = $urandom_range(25, 45);
      for (int k = 0; k < n && sent < 230; k++) begin
        make_char();
        last = ($urandom_range(11) == 0);
        for (int j = 0; j < glyph_bytes.size(); j++) begin
          send_byte(glyph_bytes[j], last && (j == glyph_bytes.size() - 1), 1'b0, no_beat);
          sent++;
        end
        if (phase == 1 && k == n / 2) settle();
      end
      phase++;
    end
    send_byte(8'h41, 1'b1, 1'b0, no_beat);

    settle();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
